[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions with asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define CHK_SAME(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low
`define CHK_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

[hw/rtl/rfnp_pkg.sv]
// ---------------------------------------------------------------------------
// rfnp_pkg
// Types and constants for the ring FIFO with negative purge.
// ---------------------------------------------------------------------------
package rfnp_pkg;

    localparam int WORD_W   = 32;
    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 4;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_PURGE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_PURGE
    } state_t;

endpackage

[hw/rtl/ring_fifo_with_negative_purge_top.sv]
// ---------------------------------------------------------------------------
// ring_fifo_with_negative_purge_top
// Circular FIFO of signed words with push, pop, peek and negative purge.
// ---------------------------------------------------------------------------
// Usage:
//   Input transactions on s_*: s_tuser carries the action (push, pop, peek,
//   purge), s_tdata the word to push. Each transaction gives exactly one
//   result transaction on m_*: m_tuser is the success flag, m_tdata holds
//   the read word (or the removed count for purge) and the fill count.
//   Push, and pop or peek on an empty FIFO: the result is registered in the
//   cycle after acceptance. Pop or peek with data: the read goes through the
//   registered read port of the slot memory, then ST_RD_WAIT loads the result
//   once the output register is free. Purge: the walk issues one memory read
//   and at most one write per cycle, then does the last write and loads the
//   result once the output register is free, so its length follows the held count.
//   s_tready is high only while the sequencer is idle and the output
//   register is empty or being emptied, so one item is in flight at a time;
//   a result waiting for m_tready holds the next item off.
//   Reset clears head, tail, count and the output valid flag; the slot
//   memory is not cleared, as no empty slot is ever read. A stalled
//   receiver holds the result register and, in turn, s_tready low.
// ---------------------------------------------------------------------------
module ring_fifo_with_negative_purge_top
    import rfnp_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [31:0] push_value
    input  logic [ACTION_W-1:0] s_tuser,   // [1:0] action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [31:0] read_value, [35:32] fill_count, [39:36] 0
    output logic [M_USER_W-1:0] m_tuser    // [0] ok
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WORD_W-1:0] mem [DEPTH];

    state_t            state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]     left_reg, left_next;
    logic [CW-1:0]     total_reg, total_next;
    logic [CW-1:0]     kept_reg, kept_next;
    logic              pend_reg, pend_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              out_ok_reg, out_ok_next;
    logic [WORD_W-1:0] out_value_reg, out_value_next;
    logic [CW-1:0]     out_count_reg, out_count_next;
    logic [WORD_W-1:0] rd_data_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic              out_free;
    logic              out_load;
    logic              accept;
    action_t           action;

    // Shared pointer step: one incrementer serves head, tail, the purge read pointer and the last purge write
    logic [AW-1:0]     step_in;
    logic [AW-1:0]     step_out;

    assign step_out = (step_in == LAST_IDX) ? '0 : step_in + AW'(1);

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign action   = action_t'(s_tuser);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        left_next      = left_reg;
        total_next     = total_reg;
        kept_next      = kept_reg;
        pend_next      = 1'b0;
        out_load       = 1'b0;
        out_ok_next    = out_ok_reg;
        out_value_next = out_value_reg;
        out_count_next = out_count_reg;
        mem_we         = 1'b0;
        mem_waddr      = tail_reg;
        mem_wdata      = s_tdata;
        mem_re         = 1'b0;
        mem_raddr      = head_reg;
        step_in        = tail_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_PUSH:
                        begin
                            out_load       = 1'b1;
                            out_value_next = '0;
                            if (count_reg != FULL_CNT)
                            begin
                                mem_we         = 1'b1;
                                step_in        = tail_reg;
                                tail_next      = step_out;
                                count_next     = count_reg + CW'(1);
                                out_ok_next    = 1'b1;
                                out_count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                out_ok_next    = 1'b0;
                                out_count_next = count_reg;
                            end
                        end
                        ACT_POP, ACT_PEEK:
                        begin
                            if (count_reg != '0)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = head_reg;
                                if (action == ACT_POP)
                                begin
                                    step_in    = head_reg;
                                    head_next  = step_out;
                                    count_next = count_reg - CW'(1);
                                end
                                state_next = ST_RD_WAIT;
                            end
                            else
                            begin
                                out_load       = 1'b1;
                                out_ok_next    = 1'b0;
                                out_value_next = '0;
                                out_count_next = count_reg;
                            end
                        end
                        default:
                        begin
                            rd_ptr_next = head_reg;
                            wr_ptr_next = head_reg;
                            left_next   = count_reg;
                            total_next  = count_reg;
                            kept_next   = '0;
                            state_next  = ST_PURGE;
                        end
                    endcase
                end
            end

            ST_RD_WAIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_ok_next    = 1'b1;
                    out_value_next = rd_data_reg;
                    out_count_next = count_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_PURGE:
            begin
                // Keep the word read last cycle if its sign bit is clear
                if (pend_reg && !rd_data_reg[WORD_W-1])
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_ptr_reg;
                    mem_wdata = rd_data_reg;
                    kept_next = kept_reg + CW'(1);
                end
                if (left_reg != '0)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = rd_ptr_reg;
                    step_in     = rd_ptr_reg;
                    rd_ptr_next = step_out;
                    left_next   = left_reg - CW'(1);
                    pend_next   = 1'b1;
                    if (mem_we)
                    begin
                        wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + AW'(1);
                    end
                end
                else if (pend_reg)
                begin
                    if (mem_we)
                    begin
                        step_in     = wr_ptr_reg;
                        wr_ptr_next = step_out;
                    end
                end
                else if (out_free)
                begin
                    // Head stays put; the kept words now run from it to the tail
                    tail_next      = wr_ptr_reg;
                    count_next     = kept_reg;
                    out_load       = 1'b1;
                    out_ok_next    = 1'b1;
                    out_value_next = WORD_W'(total_reg - kept_reg);
                    out_count_next = kept_reg;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        wr_ptr_reg    <= wr_ptr_next;
        left_reg      <= left_next;
        total_reg     <= total_next;
        kept_reg      <= kept_next;
        out_ok_reg    <= out_ok_next;
        out_value_reg <= out_value_next;
        out_count_reg <= out_count_next;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {(M_DATA_W - WORD_W - COUNT_W)'(0), COUNT_W'(out_count_reg), out_value_reg};

endmodule

[hw/rtl/rfnp_checker.sv]
// ---------------------------------------------------------------------------
// rfnp_checker
// Port-level checks for the ring FIFO with negative purge.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rfnp_checker
    import rfnp_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [ACTION_W-1:0] s_tuser,   // [1:0] action
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,   // [31:0] read_value, [35:32] fill_count
    input logic [M_USER_W-1:0] m_tuser    // [0] ok
);

    localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

    logic fail_res;
    logic purge_acc;

    assign fail_res  = m_tvalid && !m_tuser[0];
    assign purge_acc = s_tvalid && s_tready && (action_t'(s_tuser) == ACT_PURGE);

    // A failed transaction reports a zero word
    `CHK_SAME(a_fail_zero, clk, rst_n, fail_res, m_tdata[WORD_W-1:0] == '0)

    // Failure only happens on an empty or a full FIFO
    `CHK_SAME(a_fail_edge, clk, rst_n, fail_res,
              (m_tdata[35:32] == '0) || (m_tdata[35:32] == FULL_CNT))

    // Purge walk keeps the sequencer busy: no new transaction right after it
    `CHK_NEXT(a_purge_busy, clk, rst_n, purge_acc, !s_tready)

    // Stalled result holds
    `CHK_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
              m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind ring_fifo_with_negative_purge_top rfnp_checker #(.DEPTH(DEPTH)) u_rfnp_checker (.*);
